// ===== design/mmwg_pkg.sv =====
// Shared constants, codes and types for the multi-module watchdog gate.
package mmwg_pkg;

    // Default table depth
    localparam int MAX_MODULES_DEF = 8;

    // Field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 8;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 3;
    localparam int STALE_W  = 3;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_TIMEOUT = 1'b0;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 32'd1000;
    localparam logic [TICK_W-1:0] TIMEOUT_MIN = 32'd1;

    // Opcodes
    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_FEED     = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STALE   = 3'd4;

    // Slot table write command
    typedef struct packed {
        logic append;   // write a new key, clear stamp and fed flag
        logic feed;     // stamp the slot with the current tick
        logic clr_fed;  // drop every fed flag after a kick
    } wr_cmd_t;

    // Shared compare unit result
    typedef struct packed {
        logic hit;      // slot key matches the word's key
        logic fresh;    // slot was fed within the timeout
    } scan_res_t;

endpackage

// ===== design/mmwg_scan_unit.sv =====
// Shared key compare and wrapping elapsed-time compare for one slot.
module mmwg_scan_unit
    import mmwg_pkg::*;
(
    input  logic [KEY_W-1:0]  key,
    input  logic [TICK_W-1:0] now_ticks,
    input  logic [TICK_W-1:0] timeout_val,
    input  logic [KEY_W-1:0]  slot_key,
    input  logic [TICK_W-1:0] slot_last_feed,
    input  logic              slot_fed,
    output scan_res_t         res
);

    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] elapsed;

    // Treat a zero timeout as one tick
    assign limit   = (timeout_val == '0) ? TIMEOUT_MIN : timeout_val;
    // Wrapping elapsed time since the last feed
    assign elapsed = now_ticks - slot_last_feed;

    assign res.hit   = (slot_key == key);
    assign res.fresh = slot_fed && (elapsed <= limit);

endmodule

// ===== design/mmwg_slot_table.sv =====
// Slot table: module keys, last-feed stamps and fed flags.
module mmwg_slot_table
    import mmwg_pkg::*;
#(
    parameter int MAX_MODULES = MAX_MODULES_DEF,
    parameter int IDX_W       = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  idx,
    input  wr_cmd_t           wr,
    input  logic [KEY_W-1:0]  wr_key,
    input  logic [TICK_W-1:0] wr_now,
    output logic [KEY_W-1:0]  rd_key,
    output logic [TICK_W-1:0] rd_last_feed,
    output logic              rd_fed
);

    logic [KEY_W-1:0]       key_reg  [MAX_MODULES];
    logic [TICK_W-1:0]      feed_reg [MAX_MODULES];
    logic [MAX_MODULES-1:0] fed_reg;

    // Read the slot under the scan index
    assign rd_key       = key_reg[idx];
    assign rd_last_feed = feed_reg[idx];
    assign rd_fed       = fed_reg[idx];

    // Write key and stamp of the addressed slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_MODULES; i++)
        begin
            if (idx == IDX_W'(i))
            begin
                if (wr.append)
                begin
                    key_reg[i]  <= wr_key;
                    feed_reg[i] <= '0;
                end
                else if (wr.feed)
                begin
                    feed_reg[i] <= wr_now;
                end
            end
        end
    end

    // Update fed flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fed_reg <= '0;
        end
        else if (wr.clr_fed)
        begin
            fed_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_MODULES; i++)
            begin
                if (idx == IDX_W'(i))
                begin
                    if (wr.append)
                    begin
                        fed_reg[i] <= 1'b0;
                    end
                    else if (wr.feed)
                    begin
                        fed_reg[i] <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ===== design/multi_module_watchdog_gate.sv =====
// Operation: a clear needs no scan; register, feed and check scan the used slots in order
//   up to a hit or a stale slot or the end, then the result sits in the output register.
// Throughput: one word at a time; the next word is taken once the scan of the slot
//   table through the shared compare unit has committed its result to a free result register.
// Reset: asynchronous, active low; empties the table and sets the timeout to 1000 ticks.
// Top level of the multi-module watchdog gate: sequencer, config register, result register.
module multi_module_watchdog_gate
    import mmwg_pkg::*;
#(
    parameter int MAX_MODULES = MAX_MODULES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic [KEY_W-1:0]    module_key,
    input  logic [TICK_W-1:0]   now_ticks,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic                kick,
    output logic [STALE_W-1:0]  stale_slot
);

    localparam int IDX_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam int CNT_W = $clog2(MAX_MODULES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MODULES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [TICK_W-1:0]   now_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [TICK_W-1:0]   timeout_reg;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic                kick_reg;
    logic [STALE_W-1:0]  stale_reg;

    logic                accept;
    logic                at_end;
    logic                out_free;
    logic                done;
    logic                commit;
    logic [STATUS_W-1:0] res_status;
    logic                res_kick;
    logic [STALE_W-1:0]  res_stale;
    logic [CNT_W+2:0]    idx_ext;
    wr_cmd_t             wr_cmd;
    wr_cmd_t             wr_gated;
    scan_res_t           scan_res;
    logic [KEY_W-1:0]    rd_key;
    logic [TICK_W-1:0]   rd_last_feed;
    logic                rd_fed;
    logic                cfg_wr;

    // Config register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_TIMEOUT);
    assign prdata = (paddr[ADDR_W-1:2] == REG_TIMEOUT) ? timeout_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            timeout_reg <= pwdata;
        end
    end

    // Handshake
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign kick      = kick_reg;
    assign stale_slot = stale_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Slot storage and shared compare unit
    mmwg_slot_table #(
        .MAX_MODULES (MAX_MODULES),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .idx          (idx_reg[IDX_W-1:0]),
        .wr           (wr_gated),
        .wr_key       (key_reg),
        .wr_now       (now_reg),
        .rd_key       (rd_key),
        .rd_last_feed (rd_last_feed),
        .rd_fed       (rd_fed)
    );

    mmwg_scan_unit u_scan (
        .key            (key_reg),
        .now_ticks      (now_reg),
        .timeout_val    (timeout_reg),
        .slot_key       (rd_key),
        .slot_last_feed (rd_last_feed),
        .slot_fed       (rd_fed),
        .res            (scan_res)
    );

    // Decide the step for the slot under the scan index
    assign at_end  = (idx_reg == used_reg);
    assign idx_ext = (CNT_W+3)'(idx_reg);

    always_comb
    begin
        done       = 1'b0;
        res_status = ST_OK;
        res_kick   = 1'b0;
        res_stale  = '0;
        wr_cmd     = '0;
        case (op_reg)
            OP_REGISTER:
            begin
                if (at_end)
                begin
                    done = 1'b1;
                    if (used_reg == CNT_MAX)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        wr_cmd.append = 1'b1;
                    end
                end
                else if (scan_res.hit)
                begin
                    done       = 1'b1;
                    res_status = ST_ALREADY;
                end
            end
            OP_FEED:
            begin
                if (at_end)
                begin
                    done       = 1'b1;
                    res_status = ST_UNKNOWN;
                end
                else if (scan_res.hit)
                begin
                    done        = 1'b1;
                    wr_cmd.feed = 1'b1;
                end
            end
            OP_CHECK:
            begin
                if (at_end)
                begin
                    done           = 1'b1;
                    res_kick       = 1'b1;
                    wr_cmd.clr_fed = 1'b1;
                end
                else if (!scan_res.fresh)
                begin
                    done       = 1'b1;
                    res_status = ST_STALE;
                    res_stale  = idx_ext[STALE_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    // Commit only when the result register can take the word
    assign commit   = (state_reg == S_SCAN) && done && out_free;
    assign wr_gated = commit ? wr_cmd : '0;

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (!done)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (op_reg == OP_CLEAR)
                    begin
                        used_next = '0;
                    end
                    else if (wr_cmd.append)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= module_key;
            now_reg <= now_ticks;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= res_status;
            kick_reg   <= res_kick;
            stale_reg  <= res_stale;
        end
    end

endmodule

// ===== design/mmwg_checker.sv =====
// Port-level checker for the multi-module watchdog gate, bound to the top level.
module mmwg_checker
    import mmwg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic                kick,
    input logic [STALE_W-1:0]  stale_slot
);

    // A kick only comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kick |-> status == ST_OK)
        else $error("kick with non-ok status");

    // Stale index is zero unless the check was blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_STALE |-> stale_slot == '0)
        else $error("stale_slot set without stale status");

    // Only defined status codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_STALE)
        else $error("undefined status code");

    // The block is busy the cycle after it takes a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(kick)
            && $stable(stale_slot))
        else $error("stalled result changed");

endmodule

bind multi_module_watchdog_gate mmwg_checker u_mmwg_checker (.*);
